// ===== hw/rtl/ecs_pkg.sv =====
// Package for the encoder commutation sector block: constants, codes,
// controller states and the command and status structs.
// No dependencies; used by every module of the block.
package ecs_pkg;

	// Encoder counts per revolution, as a power of two.
	localparam int unsigned CPR_W = 11;
	localparam int unsigned CPR   = 1 << CPR_W;

	localparam int unsigned RAW_W   = 12;
	localparam int unsigned PP_W    = 6;
	localparam int unsigned STEP_W  = 8;
	localparam int unsigned SECT_W  = 3;
	localparam int unsigned CFG_W   = 11;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [PP_W-1:0] PP_MIN = PP_W'(1);
	localparam logic [PP_W-1:0] PP_MAX = PP_W'(32);

	localparam int unsigned NUM_SECTORS = 6;
	// Reciprocal of six for values below 256: x / 6 == (x * 171) >> 10.
	localparam int unsigned SECT_RECIP = 171;
	localparam int unsigned SECT_SHIFT = 10;

	// One quotient bit per divider step; the quotient stays below CPR.
	localparam int unsigned DIV_STEPS = CPR_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLE_PAIRS   = 2'd0,
		REG_MOTOR_OFFSET = 2'd1,
		REG_DIR_REVERSED = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		CMD_POSITION = 1'b0,
		CMD_INDEX    = 1'b1
	} in_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic capture_index;
		logic load_pos;
		logic do_mul;
		logic do_prep;
		logic do_div;
		logic do_fin;
	} dp_cmd_t;

	typedef struct packed {
		logic div_last;
	} dp_status_t;

endpackage

// ===== hw/rtl/ecs_ctrl.sv =====
// Controller for the encoder commutation sector block: state machine,
// input handshake and output valid register. Depends on ecs_pkg.
module ecs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 command,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ecs_pkg::dp_cmd_t     cmd,
	input  ecs_pkg::dp_status_t  status
);

	ecs_pkg::state_t state_q, state_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ecs_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = (state_q != ecs_pkg::ST_IDLE);
		case (state_q)
			ecs_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (command == ecs_pkg::CMD_INDEX) begin
						cmd.capture_index = 1'b1;
					end else begin
						cmd.load_pos = 1'b1;
						state_d      = ecs_pkg::ST_MUL;
					end
				end
			end
			ecs_pkg::ST_MUL: begin
				cmd.do_mul = 1'b1;
				state_d    = ecs_pkg::ST_PREP;
			end
			ecs_pkg::ST_PREP: begin
				cmd.do_prep = 1'b1;
				state_d     = ecs_pkg::ST_DIV;
			end
			ecs_pkg::ST_DIV: begin
				cmd.do_div = 1'b1;
				if (status.div_last) begin
					state_d = ecs_pkg::ST_FIN;
				end
			end
			ecs_pkg::ST_FIN: begin
				// hold until the output register is free
				if (!out_valid_q || !out_stall) begin
					cmd.do_fin = 1'b1;
					state_d    = ecs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ecs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end
		if (cmd.do_fin) begin
			out_valid_d = 1'b1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/ecs_dp.sv =====
// Datapath for the encoder commutation sector block: configuration and
// index registers, step multiplier, serial divider and output registers.
// Depends on ecs_pkg; driven by ecs_ctrl.
module ecs_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [ecs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ecs_pkg::CFG_W-1:0]           cfg_data,
	input  logic [ecs_pkg::RAW_W-1:0]           raw_count,
	input  ecs_pkg::dp_cmd_t                    cmd,
	output ecs_pkg::dp_status_t                 status,
	output logic [ecs_pkg::SECT_W-1:0]          sector,
	output logic [ecs_pkg::STEP_W-1:0]          electrical_step,
	output logic [ecs_pkg::CPR_W-1:0]           next_compare
);

	localparam int unsigned CW   = ecs_pkg::CPR_W;
	localparam int unsigned SW   = ecs_pkg::STEP_W;
	localparam int unsigned PW   = CW + SW;
	localparam int unsigned REMW = SW + 1;
	localparam int unsigned RCPW = SW + ecs_pkg::SECT_SHIFT - 2;

	logic [ecs_pkg::PP_W-1:0]  pp_q;
	logic [CW-1:0]             mo_q;
	logic                      rev_q;
	logic [ecs_pkg::RAW_W-1:0] idx_q;

	logic [CW-1:0]             cnt_q;
	logic [SW-1:0]             abs_q;
	logic [SW-1:0]             rem_q;
	logic [CW-1:0]             low_q;
	logic [CW-1:0]             quo_q;
	logic [ecs_pkg::DIV_CNT_W-1:0] iter_q;

	logic [ecs_pkg::SECT_W-1:0] sector_q;
	logic [SW-1:0]             step_q;
	logic [CW-1:0]             next_q;

	logic [ecs_pkg::PP_W-1:0]  pp_eff;
	logic [SW-1:0]             steps;
	logic [CW-1:0]             rel_cnt, dir_cnt, pos_cnt;
	logic [PW-1:0]             prod;
	logic [SW:0]               abs_inc;
	logic [SW-1:0]             inc_step;
	logic [REMW-1:0]           trial;
	logic                      qbit;
	logic [CW-1:0]             nc_off, nc_dir, nc_raw;
	logic [RCPW-1:0]           recip_prod;
	logic [SW-1:0]             sect_quo;
	logic [SW-1:0]             sect_rem;

	// configuration and index offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_q  <= ecs_pkg::PP_MIN;
			mo_q  <= '0;
			rev_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					ecs_pkg::REG_POLE_PAIRS:   pp_q  <= cfg_data[ecs_pkg::PP_W-1:0];
					ecs_pkg::REG_MOTOR_OFFSET: mo_q  <= cfg_data[CW-1:0];
					ecs_pkg::REG_DIR_REVERSED: rev_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (cmd.capture_index) begin
				idx_q <= raw_count;
			end
		end
	end

	// clamp pole pairs; steps per revolution is six times that
	always_comb begin
		pp_eff = pp_q;
		if (pp_q < ecs_pkg::PP_MIN) begin
			pp_eff = ecs_pkg::PP_MIN;
		end else if (pp_q > ecs_pkg::PP_MAX) begin
			pp_eff = ecs_pkg::PP_MAX;
		end
		steps = SW'({pp_eff, 2'b00}) + SW'({pp_eff, 1'b0});
	end

	// count relative to index, optionally reversed, minus motor offset (all mod CPR)
	always_comb begin
		rel_cnt = raw_count[CW-1:0] - idx_q[CW-1:0];
		dir_cnt = rev_q ? (CW'(0) - rel_cnt) : rel_cnt;
		pos_cnt = dir_cnt - mo_q;
	end

	assign prod = PW'(cnt_q) * PW'(steps);

	always_comb begin
		abs_inc  = {1'b0, abs_q} + (SW+1)'(1);
		inc_step = (abs_inc >= {1'b0, steps}) ? '0 : abs_inc[SW-1:0];
	end

	// restoring divider: shift in one dividend bit per step
	always_comb begin
		trial = {rem_q, low_q[CW-1]};
		qbit  = (trial >= {1'b0, steps});
	end

	assign status.div_last = (iter_q == ecs_pkg::DIV_CNT_W'(ecs_pkg::DIV_STEPS - 1));

	// map the boundary back through motor offset, reversal and index offset
	always_comb begin
		nc_off = quo_q + mo_q;
		nc_dir = rev_q ? (CW'(0) - nc_off) : nc_off;
		nc_raw = nc_dir + idx_q[CW-1:0];
	end

	always_comb begin
		recip_prod = RCPW'(abs_q) * RCPW'(ecs_pkg::SECT_RECIP);
		sect_quo   = SW'(recip_prod >> ecs_pkg::SECT_SHIFT);
		sect_rem   = abs_q - SW'(sect_quo * SW'(ecs_pkg::NUM_SECTORS));
	end

	always_ff @(posedge clk) begin
		if (cmd.load_pos) begin
			cnt_q <= pos_cnt;
		end
		if (cmd.do_mul) begin
			abs_q <= prod[PW-1:CW];
		end
		if (cmd.do_prep) begin
			// dividend is inc_step * CPR + steps - 1
			rem_q  <= inc_step;
			low_q  <= CW'(steps) - CW'(1);
			quo_q  <= '0;
			iter_q <= '0;
		end
		if (cmd.do_div) begin
			rem_q  <= qbit ? SW'(trial - {1'b0, steps}) : trial[SW-1:0];
			low_q  <= {low_q[CW-2:0], 1'b0};
			quo_q  <= {quo_q[CW-2:0], qbit};
			iter_q <= iter_q + ecs_pkg::DIV_CNT_W'(1);
		end
		if (cmd.do_fin) begin
			sector_q <= sect_rem[ecs_pkg::SECT_W-1:0];
			step_q   <= abs_q;
			next_q   <= nc_raw;
		end
	end

	assign sector          = sector_q;
	assign electrical_step = step_q;
	assign next_compare    = next_q;

endmodule

// ===== hw/rtl/encoder_commutation_sector_top.sv =====
// Position request: accepted in idle, then passes through the MUL and PREP
// states, the 11-step serial divider and FIN; no new request until idle.
// Index-capture requests are taken in idle and give no result.
// Output register frees the input side while a result waits.
// Asynchronous active-low reset: pole pairs 1, offsets 0, not reversed.
// Top level of the encoder commutation sector block; instantiates
// ecs_ctrl and ecs_dp and depends on ecs_pkg.
module encoder_commutation_sector_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [ecs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ecs_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             command,
	input  logic [ecs_pkg::RAW_W-1:0]        raw_count,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [ecs_pkg::SECT_W-1:0]       sector,
	output logic [ecs_pkg::STEP_W-1:0]       electrical_step,
	output logic [ecs_pkg::CPR_W-1:0]        next_compare
);

	ecs_pkg::dp_cmd_t    cmd;
	ecs_pkg::dp_status_t status;

	ecs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	ecs_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.raw_count       (raw_count),
		.cmd             (cmd),
		.status          (status),
		.sector          (sector),
		.electrical_step (electrical_step),
		.next_compare    (next_compare)
	);

endmodule

// ===== sim/encoder_commutation_sector_top_test.sv =====
// Self-checking testbench for encoder_commutation_sector_top: position and
// index-capture requests against a behavioural model of the sector maths.
// Depends on ecs_pkg and the RTL of the block; nothing else.
module encoder_commutation_sector_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ecs_pkg::*;

	localparam int unsigned QUIET_LIMIT     = 2000;
	localparam int unsigned SETTLE_CYCLES   = 20;
	localparam int unsigned HOLD_OFF_CYCLES = 150;
	localparam int unsigned RANDOM_PHASES   = 7;
	localparam int unsigned PHASE_ITEMS     = 75;
	localparam int unsigned MAX_REPORTS     = 10;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		in_cmd_t          cmd;
		logic [RAW_W-1:0] raw;
	} sector_request_t;

	typedef struct {
		logic [SECT_W-1:0] sector;
		logic [STEP_W-1:0] step;
		logic [CPR_W-1:0]  next_cmp;
	} commutation_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_wr_en   = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [CFG_W-1:0]     cfg_data    = '0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic                 command     = 1'b0;
	logic [RAW_W-1:0]     raw_count   = '0;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	logic [SECT_W-1:0]    sector;
	logic [STEP_W-1:0]    electrical_step;
	logic [CPR_W-1:0]     next_compare;

	// Shadow of the block's registers and index latch
	int unsigned pole_pairs_q   = 1;
	int unsigned motor_offset_q = 0;
	int unsigned reversed_q     = 0;
	int unsigned index_offset_q = 0;

	sector_request_t pending_requests[$];
	commutation_t    expected_sectors[$];
	sector_request_t next_req;
	commutation_t    want;

	logic        req_taken    = 1'b0;
	int unsigned quiet_cycles = 0;
	int unsigned issued_count, accepted_count, position_count, index_count;
	int unsigned checked_count, mismatches;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	bit          hold_trigger  = 1'b0;
	bit          hold_done     = 1'b0;
	int unsigned hold_left     = 0;

	encoder_commutation_sector_top u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.raw_count       (raw_count),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.sector          (sector),
		.electrical_step (electrical_step),
		.next_compare    (next_compare)
	);

	always #2 clk = ~clk;

	function automatic int unsigned wrap_sub(int unsigned a, int unsigned b);
		return ((a % CPR) + CPR - (b % CPR)) % CPR;
	endfunction

	function automatic commutation_t sector_of_count(int unsigned raw);
		int unsigned  pp, steps, cnt, cur, nxt, nc;
		commutation_t r;
		pp = pole_pairs_q;
		if (pp < PP_MIN)
			pp = PP_MIN;
		else if (pp > PP_MAX)
			pp = PP_MAX;
		steps = NUM_SECTORS * pp;
		cnt = wrap_sub(raw, index_offset_q);
		if (reversed_q != 0)
			cnt = CPR - cnt;
		cnt = wrap_sub(cnt, motor_offset_q);
		cur = cnt * steps / CPR;
		// wrap past the last electrical step back to step zero
		nxt = (cur + 1 >= steps) ? 0 : cur + 1;
		nc = (nxt * CPR + steps - 1) / steps;
		nc = (nc + motor_offset_q) % CPR;
		if (reversed_q != 0)
			nc = CPR - nc;
		nc = (nc + index_offset_q) % CPR;
		r.sector   = SECT_W'(cur % NUM_SECTORS);
		r.step     = STEP_W'(cur);
		r.next_cmp = CPR_W'(nc);
		return r;
	endfunction

	function automatic int unsigned random_raw();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 5)
			return CPR;
		if (pick < 8)
			return 0;
		if (pick < 11)
			return CPR - 1;
		return $urandom_range(CPR - 1);
	endfunction

	// Request driver: present a new request once the previous one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || req_taken) begin
			if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_req = pending_requests.pop_front();
				in_valid  <= 1'b1;
				command   <= next_req.cmd;
				raw_count <= next_req.raw;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stall, plus one long hold-off to fill the block
	always @(negedge clk) begin
		if (hold_trigger && !hold_done) begin
			hold_left = HOLD_OFF_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Monitor: predict on each accepted request, check each accepted result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_taken    <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			req_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				accepted_count++;
				if (command == CMD_INDEX) begin
					index_offset_q = raw_count;
					index_count++;
				end else begin
					expected_sectors.push_back(sector_of_count(raw_count));
					position_count++;
				end
			end
			if (out_valid && !out_stall) begin
				checked_count++;
				if (expected_sectors.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result: sector %0d step %0d next %0d",
							sector, electrical_step, next_compare);
				end else begin
					want = expected_sectors.pop_front();
					if (sector !== want.sector || electrical_step !== want.step ||
							next_compare !== want.next_cmp) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("mismatch: sector %0d/%0d step %0d/%0d next %0d/%0d (exp/got)",
								want.sector, sector, want.step, electrical_step,
								want.next_cmp, next_compare);
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
				$display("status: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(value);
		case (idx)
			REG_POLE_PAIRS:   pole_pairs_q   = value & ((1 << PP_W) - 1);
			REG_MOTOR_OFFSET: motor_offset_q = value & (CPR - 1);
			REG_DIR_REVERSED: reversed_q     = value & 1;
			default: ;
		endcase
	endtask

	task automatic apply_setting(input int unsigned pp, input int unsigned moff,
			input int unsigned rev, input bit poke_unused);
		write_reg(REG_POLE_PAIRS, pp);
		write_reg(REG_MOTOR_OFFSET, moff);
		write_reg(REG_DIR_REVERSED, rev);
		// an unmapped index must leave every register alone
		if (poke_unused)
			write_reg(REG_UNUSED, 'h5A5);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic queue_request(input in_cmd_t cmd, input int unsigned raw);
		sector_request_t req;
		req.cmd = cmd;
		req.raw = RAW_W'(raw);
		pending_requests.push_back(req);
		issued_count++;
	endtask

	task automatic set_idling(input int unsigned mode);
		case (mode)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 67; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 67; end
			default: begin send_idle_pct = 24; stall_pct = 24; end
		endcase
	endtask

	// Wait until every request is taken and every result is in, then settle
	task automatic wait_drain();
		do
			@(negedge clk);
		while (accepted_count != issued_count || expected_sectors.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int unsigned pp, moff, rev;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Reset settings: six steps per revolution
		set_idling(0);
		queue_request(CMD_POSITION, 0);
		queue_request(CMD_POSITION, CPR - 1);
		queue_request(CMD_POSITION, CPR);
		queue_request(CMD_POSITION, 341);
		queue_request(CMD_POSITION, 342);
		queue_request(CMD_INDEX, CPR);
		queue_request(CMD_POSITION, 5);
		queue_request(CMD_INDEX, 100);
		queue_request(CMD_POSITION, 99);
		queue_request(CMD_POSITION, 100);
		queue_request(CMD_INDEX, 0);
		wait_drain();

		// Most pole pairs, largest offset, reversed; includes reversal of zero
		apply_setting(PP_MAX, CPR - 1, 1, 1'b1);
		queue_request(CMD_POSITION, 0);
		queue_request(CMD_POSITION, CPR - 1);
		queue_request(CMD_POSITION, CPR);
		queue_request(CMD_POSITION, 1);
		queue_request(CMD_POSITION, 64);
		queue_request(CMD_INDEX, CPR - 1);
		queue_request(CMD_POSITION, CPR - 2);
		wait_drain();

		// Zero pole pairs act as one
		apply_setting(0, 0, 0, 1'b0);
		queue_request(CMD_POSITION, CPR - 1);
		queue_request(CMD_POSITION, 1000);
		queue_request(CMD_INDEX, 0);
		wait_drain();

		// Pole pairs above the maximum are clamped
		apply_setting((1 << PP_W) - 1, 0, 0, 1'b0);
		queue_request(CMD_POSITION, CPR - 1);
		queue_request(CMD_POSITION, 0);
		queue_request(CMD_POSITION, CPR / 2);
		wait_drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(9))
				0: pp = 0;
				1: pp = $urandom_range((1 << PP_W) - 1, PP_MAX + 1);
				2: pp = PP_MIN;
				3: pp = PP_MAX;
				default: pp = $urandom_range(PP_MAX, PP_MIN);
			endcase
			moff = $urandom_range(CPR - 1);
			rev  = $urandom_range(1);
			apply_setting(pp, moff, rev, 1'b0);
			set_idling(ph % 4);
			// hold the result side off while requests keep coming
			if (ph == 4)
				hold_trigger = 1'b1;
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(99) < 15)
					queue_request(CMD_INDEX, random_raw());
				else
					queue_request(CMD_POSITION, random_raw());
			end
			wait_drain();
		end

		$display("covered %0d position and %0d index requests over %0d settings,",
			position_count, index_count, RANDOM_PHASES + 4);
		$display("%0d results checked with idle, stall and hold-off on both sides",
			checked_count);
		if (mismatches == 0 && expected_sectors.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("status: fail");
		end
		$finish;
	end

endmodule
